>>> hw/rtl/gdd_pkg.sv
`timescale 1ns / 1ps

package gdd_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int COUNT_W = 22;

    localparam int unsigned MAX_YEAR_DEF = 9999;

    // quotient of a year by 100, rounded up, fits in 8 bits
    localparam int Q_W    = 8;
    // one serial day number, and the signed running difference
    localparam int TERM_W = 23;
    localparam int ACC_W  = 25;
    localparam int PC_W   = 5;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [YEAR_W-1:0]  CENTURY   = YEAR_W'(100);

    typedef enum logic [2:0] {
        OP_LOAD,
        OP_DIV,
        OP_LEAP,
        OP_ACC,
        OP_FINISH
    } op_t;

    typedef enum logic [2:0] {
        TERM_Y365,
        TERM_Y4,
        TERM_MD,
        TERM_Q,
        TERM_Q4
    } term_t;

    typedef struct packed {
        op_t             op;
        term_t           term;
        logic            sel;
        logic            neg;
        logic            jump;
        logic [PC_W-1:0] target;
    } ctrl_t;

    localparam logic [PC_W-1:0] PC_DIV_A = PC_W'(1);
    localparam logic [PC_W-1:0] PC_DIV_B = PC_W'(9);

    function automatic ctrl_t mk(op_t op, term_t term, logic sel, logic neg,
                                 logic jump, logic [PC_W-1:0] target);
        ctrl_t c;
        c.op     = op;
        c.term   = term;
        c.sel    = sel;
        c.neg    = neg;
        c.jump   = jump;
        c.target = target;
        return c;
    endfunction

    // microprogram: serial(first) - serial(second), then magnitude
    function automatic ctrl_t ucode(logic [PC_W-1:0] pc);
        ctrl_t c;
        case (pc)
            5'd0:    c = mk(OP_LOAD, TERM_Y365, 1'b0, 1'b0, 1'b0, '0);
            5'd1:    c = mk(OP_DIV,  TERM_Y365, 1'b0, 1'b0, 1'b1, PC_DIV_A);
            5'd2:    c = mk(OP_LEAP, TERM_Y365, 1'b0, 1'b0, 1'b0, '0);
            5'd3:    c = mk(OP_ACC,  TERM_Y365, 1'b0, 1'b0, 1'b0, '0);
            5'd4:    c = mk(OP_ACC,  TERM_Y4,   1'b0, 1'b0, 1'b0, '0);
            5'd5:    c = mk(OP_ACC,  TERM_MD,   1'b0, 1'b0, 1'b0, '0);
            5'd6:    c = mk(OP_ACC,  TERM_Q,    1'b0, 1'b1, 1'b0, '0);
            5'd7:    c = mk(OP_ACC,  TERM_Q4,   1'b0, 1'b0, 1'b0, '0);
            5'd8:    c = mk(OP_LOAD, TERM_Y365, 1'b1, 1'b0, 1'b0, '0);
            5'd9:    c = mk(OP_DIV,  TERM_Y365, 1'b1, 1'b0, 1'b1, PC_DIV_B);
            5'd10:   c = mk(OP_LEAP, TERM_Y365, 1'b1, 1'b0, 1'b0, '0);
            5'd11:   c = mk(OP_ACC,  TERM_Y365, 1'b1, 1'b1, 1'b0, '0);
            5'd12:   c = mk(OP_ACC,  TERM_Y4,   1'b1, 1'b1, 1'b0, '0);
            5'd13:   c = mk(OP_ACC,  TERM_MD,   1'b1, 1'b1, 1'b0, '0);
            5'd14:   c = mk(OP_ACC,  TERM_Q,    1'b1, 1'b0, 1'b0, '0);
            5'd15:   c = mk(OP_ACC,  TERM_Q4,   1'b1, 1'b1, 1'b0, '0);
            default: c = mk(OP_FINISH, TERM_Y365, 1'b0, 1'b0, 1'b0, '0);
        endcase
        return c;
    endfunction

    // month length, zero for month codes that name no month
    function automatic logic [DAY_W-1:0] month_len(logic [MONTH_W-1:0] m, logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
            4'd4, 4'd6, 4'd9, 4'd11:                   len = DAY_W'(30);
            4'd2:    len = leap ? DAY_W'(29) : DAY_W'(28);
            default: len = '0;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] days_before(logic [MONTH_W-1:0] m);
        logic [8:0] n;
        case (m)
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

endpackage

>>> hw/rtl/gregorian_date_difference.sv
`timescale 1ns / 1ps

// days between two gregorian dates
//
// input channel (s_valid / s_ready): one item is a pair of dates, each given
// as year, month and day of month. result channel (m_valid / m_ready): one
// item per input item, the day count from the earlier to the later date and
// a flag that is 1 when both dates exist in the calendar (count 0 otherwise).
//
// a small microprogram in a rom steers one adder / subtractor: for each date
// it divides the year by 100 through repeated subtraction, derives the leap
// flag, then adds or subtracts the terms of the serial day number.
// the time from accept to result valid grows with both years; the
// subtract loop sets it. one item is worked on at a time; s_ready is
// high while the sequencer idles, so no new item is taken before the
// last one is finished.
//
// the result sits in an output register; the next item is taken while it
// waits. when the receiver stalls and a new result is done, the sequencer
// holds in its last step until the register is free.
// reset (aresetn low, synchronous) empties the sequencer and the output.

module gregorian_date_difference #(
    parameter int unsigned MAX_YEAR = gdd_pkg::MAX_YEAR_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [gdd_pkg::YEAR_W-1:0]   s_first_year,
    input  logic [gdd_pkg::MONTH_W-1:0]  s_first_month,
    input  logic [gdd_pkg::DAY_W-1:0]    s_first_day,
    input  logic [gdd_pkg::YEAR_W-1:0]   s_second_year,
    input  logic [gdd_pkg::MONTH_W-1:0]  s_second_month,
    input  logic [gdd_pkg::DAY_W-1:0]    s_second_day,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [gdd_pkg::COUNT_W-1:0]  m_day_count,
    output logic                         m_dates_valid
);

    import gdd_pkg::*;

    // captured dates
    logic [YEAR_W-1:0]  ya_reg, yb_reg;
    logic [MONTH_W-1:0] ma_reg, mb_reg;
    logic [DAY_W-1:0]   da_reg, db_reg;

    // sequencer
    logic            busy_reg, busy_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    ctrl_t           cw;

    // datapath
    logic [YEAR_W-1:0]       w_reg, w_next;
    logic [Q_W-1:0]          q_reg, q_next;
    logic [1:0]              leap_reg, leap_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;

    // output register
    logic               m_valid_reg, m_valid_next;
    logic [COUNT_W-1:0] m_day_count_reg, m_day_count_next;
    logic               m_dates_valid_reg, m_dates_valid_next;

    logic               accept;
    logic               out_free;
    logic               ge100;
    logic [YEAR_W-1:0]  y_sel;
    logic [MONTH_W-1:0] m_sel;
    logic [DAY_W-1:0]   d_sel;
    logic               leap_sel;
    logic [TERM_W-1:0]  term;
    logic [ACC_W-1:0]   mag;
    logic               ok_a, ok_b;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign cw       = ucode(pc_reg);
    assign ge100    = (w_reg >= CENTURY);

    assign y_sel    = cw.sel ? yb_reg : ya_reg;
    assign m_sel    = cw.sel ? mb_reg : ma_reg;
    assign d_sel    = cw.sel ? db_reg : da_reg;
    assign leap_sel = leap_reg[cw.sel];

    // one date exists: year in range, day between 1 and the month length
    function automatic logic date_ok(logic [YEAR_W-1:0] y, logic [MONTH_W-1:0] m,
                                     logic [DAY_W-1:0] d, logic leap);
        return ({2'b00, y} <= 16'(MAX_YEAR)) && (d != '0) && (d <= month_len(m, leap));
    endfunction

    assign ok_a = date_ok(ya_reg, ma_reg, da_reg, leap_reg[0]);
    assign ok_b = date_ok(yb_reg, mb_reg, db_reg, leap_reg[1]);

    // term of the serial day number chosen by the control word
    always_comb begin
        case (cw.term)
            TERM_Y365: term = TERM_W'(y_sel) * TERM_W'(365);
            TERM_Y4:   term = TERM_W'((YEAR_W+1)'(y_sel) + (YEAR_W+1)'(3)) >> 2;
            TERM_MD:   term = TERM_W'(days_before(m_sel))
                            + TERM_W'((m_sel > MONTH_W'(2)) && leap_sel)
                            + TERM_W'(d_sel) - TERM_W'(1);
            TERM_Q:    term = TERM_W'(q_reg);
            TERM_Q4:   term = TERM_W'((Q_W+1)'(q_reg) + (Q_W+1)'(3)) >> 2;
            default:   term = '0;
        endcase
    end

    assign mag = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);

    always_comb begin
        busy_next          = busy_reg;
        pc_next            = pc_reg;
        w_next             = w_reg;
        q_next             = q_reg;
        leap_next          = leap_reg;
        acc_next           = acc_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        m_day_count_next   = m_day_count_reg;
        m_dates_valid_next = m_dates_valid_reg;

        if (accept) begin
            busy_next = 1'b1;
            pc_next   = '0;
            acc_next  = '0;
        end else if (busy_reg) begin
            pc_next = pc_reg + PC_W'(1);
            case (cw.op)
                OP_LOAD: begin
                    w_next = y_sel;
                    q_next = '0;
                end
                OP_DIV: begin
                    // floor division by 100, one subtraction per step
                    if (ge100 && cw.jump) begin
                        w_next  = w_reg - CENTURY;
                        q_next  = q_reg + Q_W'(1);
                        pc_next = cw.target;
                    end
                end
                OP_LEAP: begin
                    // century years are leap only when divisible by 400
                    leap_next[cw.sel] = (w_reg == '0) ? (q_reg[1:0] == 2'b00)
                                                      : (y_sel[1:0] == 2'b00);
                    // q becomes year / 100 rounded up
                    q_next = q_reg + Q_W'(w_reg != '0);
                end
                OP_ACC: begin
                    if (cw.neg) begin
                        acc_next = acc_reg - signed'(ACC_W'(term));
                    end else begin
                        acc_next = acc_reg + signed'(ACC_W'(term));
                    end
                end
                OP_FINISH: begin
                    pc_next = pc_reg;
                    if (out_free) begin
                        busy_next          = 1'b0;
                        m_valid_next       = 1'b1;
                        m_dates_valid_next = ok_a && ok_b;
                        if (!(ok_a && ok_b)) begin
                            m_day_count_next = '0;
                        end else if (mag > ACC_W'(COUNT_MAX)) begin
                            m_day_count_next = COUNT_MAX;
                        end else begin
                            m_day_count_next = mag[COUNT_W-1:0];
                        end
                    end
                end
                default: begin
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            pc_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            pc_reg      <= pc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            ya_reg <= s_first_year;
            ma_reg <= s_first_month;
            da_reg <= s_first_day;
            yb_reg <= s_second_year;
            mb_reg <= s_second_month;
            db_reg <= s_second_day;
        end
        w_reg             <= w_next;
        q_reg             <= q_next;
        leap_reg          <= leap_next;
        acc_reg           <= acc_next;
        m_day_count_reg   <= m_day_count_next;
        m_dates_valid_reg <= m_dates_valid_next;
    end

    assign s_ready       = !busy_reg;
    assign m_valid       = m_valid_reg;
    assign m_day_count   = m_day_count_reg;
    assign m_dates_valid = m_dates_valid_reg;

endmodule

>>> tb/sv/gregorian_date_difference_tb.sv
`timescale 1ns / 1ps

module gregorian_date_difference_tb;

    localparam int YW = gdd_pkg::YEAR_W;
    localparam int MW = gdd_pkg::MONTH_W;
    localparam int DW = gdd_pkg::DAY_W;
    localparam int CW = gdd_pkg::COUNT_W;

    localparam int unsigned LAST_YEAR   = gdd_pkg::MAX_YEAR_DEF;
    localparam int unsigned COUNT_LIMIT = (1 << CW) - 1;

    localparam int NUM_RANDOM    = 600;
    // longer than the worst-case latency plus the output register
    localparam int SETTLE_CYCLES = 400;
    // slowest run: ~625 items, each up to the worst-case work, a sender gap
    // and a long receiver stall, taken several times over
    localparam int LIMIT_CYCLES  = 1_500_000;
    localparam int MAX_PRINTED   = 50;

    // one query as it sits in the send queue
    typedef struct {
        logic [YW-1:0] y1;
        logic [MW-1:0] m1;
        logic [DW-1:0] d1;
        logic [YW-1:0] y2;
        logic [MW-1:0] m2;
        logic [DW-1:0] d2;
        bit            hold_for_drain;  // wait until all results are back first
    } date_pair_t;

    // the day span that a query must produce, with the query kept for messages
    typedef struct {
        date_pair_t    pair;
        logic [CW-1:0] count;
        logic          valid;
    } span_t;

    // ways to spoil a date for the malformed part of the stimulus
    typedef enum int {
        FLAW_YEAR,
        FLAW_MONTH,
        FLAW_DAY_ZERO,
        FLAW_DAY_PAST,
        FLAW_FEB_29,
        FLAW_NOISE
    } flaw_t;

    // receiver stall patterns
    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_COMB
    } rx_mode_t;

    // every input known from time zero
    logic          aclk           = 1'b0;
    logic          aresetn        = 1'b0;
    logic          s_valid        = 1'b0;
    logic          s_ready;
    logic [YW-1:0] s_first_year   = '0;
    logic [MW-1:0] s_first_month  = '0;
    logic [DW-1:0] s_first_day    = '0;
    logic [YW-1:0] s_second_year  = '0;
    logic [MW-1:0] s_second_month = '0;
    logic [DW-1:0] s_second_day   = '0;
    logic          m_valid;
    logic          m_ready        = 1'b0;
    logic [CW-1:0] m_day_count;
    logic          m_dates_valid;

    date_pair_t date_pairs[$];      // queries not yet offered
    span_t      expected_spans[$];  // spans of accepted queries, oldest first
    date_pair_t in_flight;          // query currently on the input port

    int mismatches     = 0;
    int cycle_count    = 0;
    int pairs_sent     = 0;
    int pairs_good     = 0;
    int pairs_bad      = 0;
    int results_seen   = 0;
    int drain_holds    = 0;
    int unsigned longest_span = 0;

    gregorian_date_difference uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_first_year   (s_first_year),
        .s_first_month  (s_first_month),
        .s_first_day    (s_first_day),
        .s_second_year  (s_second_year),
        .s_second_month (s_second_month),
        .s_second_day   (s_second_day),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_day_count    (m_day_count),
        .m_dates_valid  (m_dates_valid)
    );

    always #2 aclk = ~aclk;

    // ---------------------------------------------------------------
    // calendar arithmetic for the expected spans
    // ---------------------------------------------------------------

    // gregorian rule, year 0 included as a leap year
    function automatic bit is_leap_year(int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // zero for month codes that name no month
    function automatic int unsigned days_in_month(int unsigned y, int unsigned m);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return is_leap_year(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    function automatic bit date_exists(int unsigned y, int unsigned m, int unsigned d);
        return (y <= LAST_YEAR) && (d >= 1) && (d <= days_in_month(y, m));
    endfunction

    // days since 1 january of year 0; leap days of earlier years are counted
    // by rounding up, then the months before this one are walked
    function automatic int unsigned day_number(int unsigned y, int unsigned m,
                                               int unsigned d);
        int unsigned n;
        int unsigned k;
        n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
        for (k = 1; k < m; k++)
            n += days_in_month(y, k);
        return n + d - 1;
    endfunction

    function automatic span_t predict_span(date_pair_t p);
        span_t       r;
        int unsigned a;
        int unsigned b;
        int unsigned gap;
        r.pair  = p;
        r.count = '0;
        r.valid = 1'b0;
        // a malformed date on either side gives count 0, flag 0
        if (date_exists(32'(p.y1), 32'(p.m1), 32'(p.d1))
                && date_exists(32'(p.y2), 32'(p.m2), 32'(p.d2))) begin
            a   = day_number(32'(p.y1), 32'(p.m1), 32'(p.d1));
            b   = day_number(32'(p.y2), 32'(p.m2), 32'(p.d2));
            gap = (a > b) ? a - b : b - a;
            if (gap > COUNT_LIMIT)
                gap = COUNT_LIMIT;
            r.count = gap[CW-1:0];
            r.valid = 1'b1;
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    task automatic add_pair(int unsigned y1, int unsigned m1, int unsigned d1,
                            int unsigned y2, int unsigned m2, int unsigned d2,
                            bit hold);
        date_pair_t p;
        p.y1 = YW'(y1);
        p.m1 = MW'(m1);
        p.d1 = DW'(d1);
        p.y2 = YW'(y2);
        p.m2 = MW'(m2);
        p.d2 = DW'(d2);
        p.hold_for_drain = hold;
        date_pairs.push_back(p);
    endtask

    // years weighted toward the places where the leap rule turns
    function automatic int unsigned pick_year();
        case ($urandom_range(0, 7))
            0:       return $urandom_range(0, 40);
            1:       return 100 * $urandom_range(1, 99) + $urandom_range(0, 2) - 1;
            2:       return 400 * $urandom_range(0, 24);
            3:       return LAST_YEAR - $urandom_range(0, 30);
            default: return $urandom_range(0, LAST_YEAR);
        endcase
    endfunction

    task automatic make_valid_date(output int unsigned y, output int unsigned m,
                                   output int unsigned d);
        y = pick_year();
        m = $urandom_range(1, 12);
        // favor month ends, where february and leap years matter
        if ($urandom_range(0, 3) == 0)
            d = days_in_month(y, m);
        else
            d = $urandom_range(1, days_in_month(y, m));
    endtask

    task automatic spoil_date(inout int unsigned y, inout int unsigned m,
                              inout int unsigned d);
        flaw_t kind;
        kind = flaw_t'($urandom_range(FLAW_YEAR, FLAW_NOISE));
        case (kind)
            FLAW_YEAR:     y = $urandom_range(LAST_YEAR + 1, (1 << YW) - 1);
            FLAW_MONTH: begin
                // month 0 or one of the codes past december
                m = $urandom_range(0, 3);
                if (m != 0)
                    m += 12;
            end
            FLAW_DAY_ZERO: d = 0;
            FLAW_DAY_PAST: begin
                if (days_in_month(y, m) == 31) begin
                    m = 6;
                    d = 31;
                end else begin
                    d = $urandom_range(days_in_month(y, m) + 1, 31);
                end
            end
            FLAW_FEB_29: begin
                // 29 february of a common year
                if (is_leap_year(y))
                    y = y + 1;
                m = 2;
                d = 29;
            end
            default: begin
                y = $urandom_range(0, (1 << YW) - 1);
                m = $urandom_range(0, (1 << MW) - 1);
                d = $urandom_range(0, (1 << DW) - 1);
            end
        endcase
    endtask

    task automatic add_random_pair(bit hold);
        int unsigned y1, m1, d1, y2, m2, d2;
        int unsigned pick;
        make_valid_date(y1, m1, d1);
        make_valid_date(y2, m2, d2);
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            // same date twice
            y2 = y1;
            m2 = m1;
            d2 = d1;
        end else if (pick < 20) begin
            // nearby dates, often across a year boundary
            y2 = y1 + $urandom_range(0, 2);
            if (y2 > LAST_YEAR)
                y2 = y1;
            m2 = $urandom_range(1, 12);
            d2 = $urandom_range(1, days_in_month(y2, m2));
        end else if (pick < 34) begin
            // one or both dates malformed
            if ($urandom_range(0, 1) == 0)
                spoil_date(y1, m1, d1);
            else
                spoil_date(y2, m2, d2);
            if ($urandom_range(0, 4) == 0)
                spoil_date(y1, m1, d1);
        end
        add_pair(y1, m1, d1, y2, m2, d2, hold);
    endtask

    task automatic flag_mismatch(string what);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    // ---------------------------------------------------------------
    // driver: bursts of items separated by random gaps
    // ---------------------------------------------------------------

    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge aclk) begin
        date_pair_t nxt;
        span_t      span;
        bit         launch;
        if (!aresetn) begin
            s_valid    <= 1'b0;
            burst_left = $urandom_range(1, 20);
            gap_left   = 0;
        end else begin
            if (s_valid && s_ready) begin
                span = predict_span(in_flight);
                expected_spans.push_back(span);
                pairs_sent++;
                if (span.valid)
                    pairs_good++;
                else
                    pairs_bad++;
            end
            // the port is free when nothing is offered or the offer just went in
            if (!s_valid || s_ready) begin
                launch = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (date_pairs.size() != 0) begin
                    // a marked item waits for the block to drain completely
                    if (!(date_pairs[0].hold_for_drain && expected_spans.size() != 0))
                        launch = 1'b1;
                end
                if (launch) begin
                    nxt = date_pairs.pop_front();
                    if (nxt.hold_for_drain)
                        drain_holds++;
                    in_flight      = nxt;
                    s_first_year   <= nxt.y1;
                    s_first_month  <= nxt.m1;
                    s_first_day    <= nxt.d1;
                    s_second_year  <= nxt.y2;
                    s_second_month <= nxt.m2;
                    s_second_day   <= nxt.d2;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 20);
                        // about a third of the bursts run straight on
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
                    end
                end
                s_valid <= launch;
            end
        end
    end

    // ---------------------------------------------------------------
    // receiver: stall pattern switches at random among four schemes of ready cycles
    // ---------------------------------------------------------------

    rx_mode_t rx_mode = RX_OPEN;
    int       rx_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(RX_OPEN, RX_COMB));
                rx_left = $urandom_range(50, 400);
            end else begin
                rx_left--;
            end
            case (rx_mode)
                RX_OPEN:   m_ready <= 1'b1;
                RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_ready <= ($urandom_range(0, 7) == 0);
                default:   m_ready <= (rx_left % 5 != 0);
            endcase
        end
    end

    // ---------------------------------------------------------------
    // monitor: each result against the oldest expected span
    // ---------------------------------------------------------------

    always @(posedge aclk) begin
        span_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_spans.size() == 0) begin
                flag_mismatch($sformatf("result with no item pending: count=%0d flag=%0b",
                                        m_day_count, m_dates_valid));
            end else begin
                want = expected_spans.pop_front();
                if (m_day_count !== want.count)
                    flag_mismatch($sformatf("%0d-%0d-%0d / %0d-%0d-%0d: count %0d, want %0d",
                                            want.pair.y1, want.pair.m1, want.pair.d1,
                                            want.pair.y2, want.pair.m2, want.pair.d2,
                                            m_day_count, want.count));
                if (m_dates_valid !== want.valid)
                    flag_mismatch($sformatf("%0d-%0d-%0d / %0d-%0d-%0d: flag %0b, want %0b",
                                            want.pair.y1, want.pair.m1, want.pair.d1,
                                            want.pair.y2, want.pair.m2, want.pair.d2,
                                            m_dates_valid, want.valid));
                if (want.valid && 32'(want.count) > longest_span)
                    longest_span = 32'(want.count);
            end
        end
    end

    // ---------------------------------------------------------------
    // watchdog
    // ---------------------------------------------------------------

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_spans.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus and end of run
    // ---------------------------------------------------------------

    initial begin
        int k;

        // directed: extremes, leap rule corners and every kind of bad date
        add_pair(2000, 1, 1, 2000, 1, 1, 1'b0);         // equal dates
        add_pair(9999, 12, 31, 9999, 12, 31, 1'b0);     // equal, top of range
        add_pair(0, 1, 1, 9999, 12, 31, 1'b0);          // widest span
        add_pair(9999, 12, 31, 0, 1, 1, 1'b0);          // same, later date first
        add_pair(2000, 2, 29, 2000, 3, 1, 1'b0);        // leap by the 400 rule
        add_pair(1900, 2, 28, 1900, 3, 1, 1'b0);        // century, not leap
        add_pair(1900, 2, 29, 1900, 3, 1, 1'b0);        // no such day in 1900
        add_pair(2004, 2, 29, 2003, 2, 28, 1'b0);       // ordinary leap year
        add_pair(0, 2, 29, 0, 3, 1, 1'b0);              // year 0 is leap
        add_pair(2100, 2, 28, 2100, 3, 1, 1'b0);
        add_pair(2400, 2, 29, 2399, 12, 31, 1'b0);
        add_pair(1999, 12, 31, 2000, 1, 1, 1'b0);       // across a year boundary
        add_pair(1, 1, 31, 1, 12, 31, 1'b0);            // day field all ones
        add_pair(2023, 2, 29, 2023, 3, 1, 1'b0);        // feb 29 in a common year
        add_pair(2020, 0, 10, 2020, 5, 5, 1'b0);        // month 0
        add_pair(2020, 5, 5, 2020, 13, 1, 1'b0);        // month past december
        add_pair(2020, 15, 31, 2020, 1, 1, 1'b0);       // month field all ones
        add_pair(2020, 5, 0, 2020, 5, 5, 1'b0);         // day 0
        add_pair(2021, 4, 31, 2021, 5, 1, 1'b0);        // day past a 30-day month
        add_pair(10000, 1, 1, 9999, 12, 31, 1'b0);      // year just past the limit
        add_pair(2000, 6, 15, 16383, 6, 15, 1'b0);      // year field all ones
        add_pair(16383, 15, 31, 0, 0, 0, 1'b0);         // both dates malformed
        add_pair(8192, 8, 16, 4096, 4, 8, 1'b0);        // single high bits

        // random queries; the first waits for an empty pipe
        for (k = 0; k < NUM_RANDOM; k++)
            add_random_pair((k == 0) || ($urandom_range(0, 49) == 0));

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // look at settled values only, away from the driving edge
        while (date_pairs.size() != 0 || s_valid || expected_spans.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("date pairs sent %0d (%0d with both dates valid, %0d malformed), results %0d",
                 pairs_sent, pairs_good, pairs_bad, results_seen);
        $display("longest span %0d days, %0d drain holds, %0d mismatches",
                 longest_span, drain_holds, mismatches);
        if (mismatches == 0 && expected_spans.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
